// ===== src/bale_pkg.sv =====
// Package for the bounded array list engine: sizes, codes and payload types.
`timescale 1ns / 1ps

package bale_pkg;

  localparam int DEPTH     = 16;
  localparam int KEY_WIDTH = 32;

  // Keys arrive on a 32-bit field, so at most 32 key bits are ever stored.
  localparam int KeyStW = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
  localparam int AddrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW   = $clog2(DEPTH + 1);
  localparam int CmpW   = (CntW > 5) ? CntW : 5;

  localparam logic [4:0] CapReset = 5'd16;

  typedef enum logic [2:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DELETE    = 3'd3,
    OP_UPDATE    = 3'd4,
    OP_READ      = 3'd5,
    OP_SEARCH    = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  position;
    logic [31:0] record_name;
    logic [31:0] record_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  found_index;
    logic [31:0] read_name;
    logic [31:0] read_data;
    logic [4:0]  entry_total;
  } out_item_t;

  typedef struct packed {
    logic [KeyStW-1:0] key;
    logic [31:0]       data;
  } rec_t;

endpackage

// ===== src/bounded_array_list_engine.sv =====
// Top level of the bounded array list engine: list memory, sequencer and output register.
`timescale 1ns / 1ps

// Usage. One input transfer on in_valid_i/in_stall_o carries one list operation
// (insert first, insert last, insert at, delete, update, read, search). Each
// operation yields exactly one result transfer on out_valid_o/out_stall_i with
// status, found index, the record read and the record count after the operation.
// The capacity register is written through cfg_we_i/cfg_wdata_i; the user must write
// it only while idle, as the block itself does not enforce this. Records live in one
// synchronous memory with a registered read, so every shift and every search step
// handles the entries one at a time. Append and update write the record directly;
// an insert below the count first moves the entries from the last one down to the
// position up by one place; a delete moves the later entries down by one place; a
// search reads from entry 0 until a match or the last entry.
// The memory port allows one read and one write per cycle.
// The block works on one item at a time; the result waits in an output register,
// and a stalled receiver holds the block only once the next result is ready.
// Reset empties the list and sets the capacity to 16; the memory is not cleared,
// since no entry at or above the count is ever read.

module bounded_array_list_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [4:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bale_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bale_pkg::out_item_t  out_item_o
);

  localparam int AddrW  = bale_pkg::AddrW;
  localparam int CntW   = bale_pkg::CntW;
  localparam int CmpW   = bale_pkg::CmpW;
  localparam int KeyStW = bale_pkg::KeyStW;

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SHIFT = 6'b000010,
    S_FILL  = 6'b000100,
    S_READ  = 6'b001000,
    S_SCAN  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [4:0]          cap_q;
  logic [AddrW-1:0]    ptr_q, ptr_d;
  logic [AddrW-1:0]    end_q, end_d;
  logic                up_q, up_d;
  logic [KeyStW-1:0]   key_q, key_d;
  logic [31:0]         data_q, data_d;
  bale_pkg::out_item_t res_q, res_d;
  bale_pkg::out_item_t out_q;
  logic                out_valid_q;
  logic                load_out;

  // List memory with one write and one registered read per cycle.
  bale_pkg::rec_t      mem [bale_pkg::DEPTH];
  logic                we, re;
  logic [AddrW-1:0]    wa, ra;
  bale_pkg::rec_t      wd;
  bale_pkg::rec_t      rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_q <= mem[ra];
    end
  end

  // Count and capacity compared in one common width. The effective limit is the
  // capacity saturated to the memory depth.
  logic [CmpW-1:0] cnt_c, cap_c, pos_c, ins_c;
  logic            full;

  assign cnt_c = CmpW'(cnt_q);
  assign cap_c = CmpW'(cap_q);
  assign pos_c = CmpW'(in_item_i.position);
  assign full  = (cnt_c >= cap_c) || (cnt_q == CntW'(bale_pkg::DEPTH));

  always_comb begin
    unique case (in_item_i.op)
      bale_pkg::OP_INS_FIRST: ins_c = '0;
      bale_pkg::OP_INS_LAST:  ins_c = cnt_c;
      default:                ins_c = pos_c;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ptr_d    = ptr_q;
    end_d    = end_q;
    up_d     = up_q;
    key_d    = key_q;
    data_d   = data_q;
    res_d    = res_q;
    we       = 1'b0;
    wa       = '0;
    wd       = '0;
    re       = 1'b0;
    ra       = '0;
    load_out = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          key_d   = in_item_i.record_name[KeyStW-1:0];
          data_d  = in_item_i.record_data;
          res_d   = '0;
          state_d = S_DONE;
          unique case (in_item_i.op)
            bale_pkg::OP_INS_FIRST, bale_pkg::OP_INS_LAST, bale_pkg::OP_INS_AT: begin
              // Full is checked before the position.
              if (full) begin
                res_d.status = bale_pkg::ST_FULL;
              end else if (in_item_i.op == bale_pkg::OP_INS_AT && pos_c > cnt_c) begin
                res_d.status = bale_pkg::ST_BADPOS;
              end else begin
                cnt_d = cnt_q + CntW'(1);
                if (ins_c == cnt_c) begin
                  // Appending needs no shift.
                  we = 1'b1;
                  wa = AddrW'(cnt_q);
                  wd = '{key: key_d, data: data_d};
                end else begin
                  // Move entries up, starting from the last one.
                  re      = 1'b1;
                  ra      = AddrW'(cnt_q - CntW'(1));
                  ptr_d   = ra;
                  end_d   = AddrW'(ins_c);
                  up_d    = 1'b1;
                  state_d = S_SHIFT;
                end
              end
            end
            bale_pkg::OP_DELETE: begin
              if (cnt_q == '0) begin
                res_d.status = bale_pkg::ST_EMPTY;
              end else if (pos_c >= cnt_c) begin
                res_d.status = bale_pkg::ST_BADPOS;
              end else begin
                cnt_d = cnt_q - CntW'(1);
                // Deleting the last entry only drops the count.
                if (pos_c != CmpW'(cnt_d)) begin
                  re      = 1'b1;
                  ra      = AddrW'(in_item_i.position) + AddrW'(1);
                  ptr_d   = ra;
                  end_d   = AddrW'(cnt_d);
                  up_d    = 1'b0;
                  state_d = S_SHIFT;
                end
              end
            end
            bale_pkg::OP_UPDATE: begin
              if (pos_c >= cnt_c) begin
                res_d.status = bale_pkg::ST_BADPOS;
              end else begin
                we = 1'b1;
                wa = AddrW'(in_item_i.position);
                wd = '{key: key_d, data: data_d};
              end
            end
            bale_pkg::OP_READ: begin
              if (pos_c >= cnt_c) begin
                res_d.status = bale_pkg::ST_BADPOS;
              end else begin
                re      = 1'b1;
                ra      = AddrW'(in_item_i.position);
                state_d = S_READ;
              end
            end
            bale_pkg::OP_SEARCH: begin
              if (cnt_q == '0) begin
                res_d.status = bale_pkg::ST_NOTFOUND;
              end else begin
                re      = 1'b1;
                ra      = '0;
                ptr_d   = '0;
                state_d = S_SCAN;
              end
            end
            default: begin
              // The unused code leaves the list alone and reports success.
            end
          endcase
          // The count after the operation is known once it is accepted.
          res_d.entry_total = 5'(cnt_d);
        end
      end

      S_SHIFT: begin
        // The entry read last cycle moves one place up or down.
        we = 1'b1;
        wd = rdata_q;
        wa = up_q ? (ptr_q + AddrW'(1)) : (ptr_q - AddrW'(1));
        if (ptr_q == end_q) begin
          state_d = up_q ? S_FILL : S_DONE;
        end else begin
          re    = 1'b1;
          ra    = up_q ? (ptr_q - AddrW'(1)) : (ptr_q + AddrW'(1));
          ptr_d = ra;
        end
      end

      S_FILL: begin
        we      = 1'b1;
        wa      = end_q;
        wd      = '{key: key_q, data: data_q};
        state_d = S_DONE;
      end

      S_READ: begin
        res_d.read_name = 32'(rdata_q.key);
        res_d.read_data = rdata_q.data;
        state_d         = S_DONE;
      end

      S_SCAN: begin
        if (rdata_q.key == key_q) begin
          res_d.found_index = 4'(ptr_q);
          state_d           = S_DONE;
        end else if (ptr_q == AddrW'(cnt_q - CntW'(1))) begin
          res_d.status = bale_pkg::ST_NOTFOUND;
          state_d      = S_DONE;
        end else begin
          re    = 1'b1;
          ra    = ptr_q + AddrW'(1);
          ptr_d = ra;
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cap_q       <= bale_pkg::CapReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      out_valid_q <= load_out | (out_valid_q & out_stall_i);
    end
  end

  // Working and result registers carry payload only.
  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    end_q  <= end_d;
    up_q   <= up_d;
    key_q  <= key_d;
    data_q <= data_d;
    res_q  <= res_d;
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // The count never passes the memory depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(bale_pkg::DEPTH))
    else $error("entry count exceeds depth");

  // A shift step never reads the entry it writes in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re) |-> (wa != ra))
    else $error("memory read and write collide");

  // A search only visits filled entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CmpW'(ptr_q) < cnt_c))
    else $error("search pointer beyond count");

  // A new result appears only out of the done state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside done state");

endmodule
